>>> rtl/rpd_pkg.sv
// Package: shared types, register map and reset values for the radar presence debouncer.
`timescale 1ns / 1ps
package rpd_pkg;

  typedef enum logic [1:0] {
    PRES_UNKNOWN = 2'd0,
    PRES_CLEAR   = 2'd1,
    PRES_PRESENT = 2'd2
  } presence_t;

  typedef enum logic [2:0] {
    REG_STALL_TIMEOUT    = 3'd0,
    REG_PRESENT_DEBOUNCE = 3'd1,
    REG_CLEAR_TIMEOUT    = 3'd2,
    REG_NEAR_LIMIT       = 3'd3,
    REG_MID_LIMIT        = 3'd4
  } reg_index_t;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned SpanWidth = 31;
  localparam int unsigned DistWidth = 16;

  localparam logic [SpanWidth-1:0] StallTimeoutReset    = 31'd3000;
  localparam logic [SpanWidth-1:0] PresentDebounceReset = 31'd1000;
  localparam logic [SpanWidth-1:0] ClearTimeoutReset    = 31'd5000;
  localparam logic [DistWidth-1:0] NearLimitReset       = 16'd100;
  localparam logic [DistWidth-1:0] MidLimitReset        = 16'd300;

  typedef struct packed {
    logic [SpanWidth-1:0] stall_timeout;
    logic [SpanWidth-1:0] present_debounce;
    logic [SpanWidth-1:0] clear_timeout;
    logic [DistWidth-1:0] near_limit;
    logic [DistWidth-1:0] mid_limit;
  } rpd_cfg_t;

  typedef struct packed {
    logic                 command;
    logic [TimeWidth-1:0] now_ms;
    logic                 frame_is_presence;
    logic                 target_hit;
    logic [7:0]           raw_targets;
    logic [DistWidth-1:0] range_cm;
  } rpd_item_t;

  typedef struct packed {
    presence_t            presence;
    logic [1:0]           count;
    logic [1:0]           range;
    logic [TimeWidth-1:0] last_frame;
    logic [TimeWidth-1:0] target_start;
    logic [TimeWidth-1:0] absence_start;
    logic                 last_raw_target;
  } rpd_state_t;

  typedef struct packed {
    presence_t  presence;
    logic [1:0] count;
    logic [1:0] range;
    logic       presence_chg;
    logic       bucket_chg;
    logic       stalled;
  } rpd_result_t;

endpackage

>>> rtl/rpd_step.sv
// Next-state and result logic for one tick of the presence debouncer.
`timescale 1ns / 1ps
module rpd_step import rpd_pkg::*; (
  input  rpd_cfg_t    cfg,
  input  rpd_item_t   item,
  input  rpd_state_t  cur,
  output rpd_state_t  nxt,
  output rpd_result_t res
);

  // now - since read as signed 32 bit, non-negative and >= span
  function automatic logic span_passed(input logic [TimeWidth-1:0] now,
                                       input logic [TimeWidth-1:0] since,
                                       input logic [SpanWidth-1:0] span);
    logic [TimeWidth-1:0] d;
    d = now - since;
    return !d[TimeWidth-1] && (d[SpanWidth-1:0] >= span);
  endfunction

  logic [TimeWidth-1:0] tgt_start;
  logic [TimeWidth-1:0] abs_start;
  logic [1:0]           bucket;
  logic [1:0]           band;
  logic                 stall_hit;

  assign stall_hit = (cur.presence != PRES_UNKNOWN) &&
                     span_passed(item.now_ms, cur.last_frame, cfg.stall_timeout);
  assign tgt_start = (item.target_hit && !cur.last_raw_target) ? item.now_ms
                                                               : cur.target_start;
  assign abs_start = (!item.target_hit && cur.last_raw_target) ? item.now_ms
                                                               : cur.absence_start;

  always_comb begin
    if (item.raw_targets == 8'd0) begin
      bucket = 2'd0;
    end else if (item.raw_targets == 8'd1) begin
      bucket = 2'd1;
    end else begin
      bucket = 2'd2;
    end
    if (item.range_cm == '0) begin
      band = 2'd0;
    end else if (item.range_cm <= cfg.near_limit) begin
      band = 2'd1;
    end else if (item.range_cm <= cfg.mid_limit) begin
      band = 2'd2;
    end else begin
      band = 2'd3;
    end
  end

  always_comb begin
    nxt = cur;
    res.presence_chg = 1'b0;
    res.bucket_chg   = 1'b0;
    res.stalled      = 1'b0;
    if (item.command) begin
      nxt.presence        = PRES_UNKNOWN;
      nxt.count           = 2'd0;
      nxt.range           = 2'd0;
      nxt.last_frame      = item.now_ms;
      nxt.target_start    = item.now_ms;
      nxt.absence_start   = item.now_ms;
      nxt.last_raw_target = 1'b0;
      res.presence_chg    = (cur.presence != PRES_UNKNOWN);
    end else if (stall_hit) begin
      nxt.presence     = PRES_UNKNOWN;
      nxt.count        = 2'd0;
      nxt.range        = 2'd0;
      res.presence_chg = 1'b1;
      res.stalled      = 1'b1;
    end else if (item.frame_is_presence) begin
      nxt.last_frame      = item.now_ms;
      nxt.target_start    = tgt_start;
      nxt.absence_start   = abs_start;
      nxt.last_raw_target = item.target_hit;
      if (item.target_hit) begin
        if (cur.presence != PRES_PRESENT &&
            span_passed(item.now_ms, tgt_start, cfg.present_debounce)) begin
          nxt.presence = PRES_PRESENT;
        end else if (cur.presence == PRES_UNKNOWN) begin
          nxt.presence = PRES_CLEAR;
        end
        nxt.count = bucket;
        nxt.range = band;
      end else begin
        if (cur.presence != PRES_CLEAR &&
            span_passed(item.now_ms, abs_start, cfg.clear_timeout)) begin
          nxt.presence = PRES_CLEAR;
        end else if (cur.presence == PRES_UNKNOWN) begin
          nxt.presence = PRES_CLEAR;
        end
        nxt.count = 2'd0;
        nxt.range = 2'd0;
      end
      res.presence_chg = (nxt.presence != cur.presence);
      res.bucket_chg   = (nxt.count != cur.count);
    end
    res.presence = nxt.presence;
    res.count    = nxt.count;
    res.range    = nxt.range;
  end

endmodule

>>> rtl/radar_presence_debounce_fsm.sv
// Top level: radar presence debouncer with input register, result register and APB registers.
//
//  channel | valid    | stall     | payload
//  --------+----------+-----------+----------------------------------------------
//  in      | in_valid | in_stall  | command now_ms frame_is_presence target_hit
//          |          |           | raw_targets range_cm
//  out     | out_valid| out_stall | presence_state count_bucket range_band
//          |          |           | presence_chg bucket_chg stalled
//  cfg     | psel     | (pready)  | paddr pwdata prdata, registers at 4*index
//
// One word per cycle while out_stall stays low; out_valid rises as the word enters the result register.
// The input register feeds the step logic, which updates the state and the
// result register in the same edge, so back-to-back words see fresh state.
// Reset (rst, synchronous) empties both registers and rearms the state at time 0.
// A held result stalls the input register, which then raises in_stall.
`timescale 1ns / 1ps
module radar_presence_debounce_fsm import rpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [TimeWidth-1:0] now_ms,
  input  logic                 frame_is_presence,
  input  logic                 target_hit,
  input  logic [7:0]           raw_targets,
  input  logic [DistWidth-1:0] range_cm,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           presence_state,
  output logic [1:0]           count_bucket,
  output logic [1:0]           range_band,
  output logic                 presence_chg,
  output logic                 bucket_chg,
  output logic                 stalled,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  rpd_cfg_t    cfg;
  rpd_item_t   item;
  logic        item_valid;
  rpd_state_t  state;
  rpd_state_t  state_next;
  rpd_result_t result;
  rpd_result_t step_res;
  logic        advance;
  logic        cfg_write;
  reg_index_t  reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_index_t'(paddr[AddrWidth-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_timeout    <= StallTimeoutReset;
      cfg.present_debounce <= PresentDebounceReset;
      cfg.clear_timeout    <= ClearTimeoutReset;
      cfg.near_limit       <= NearLimitReset;
      cfg.mid_limit        <= MidLimitReset;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_STALL_TIMEOUT:    cfg.stall_timeout    <= pwdata[SpanWidth-1:0];
        REG_PRESENT_DEBOUNCE: cfg.present_debounce <= pwdata[SpanWidth-1:0];
        REG_CLEAR_TIMEOUT:    cfg.clear_timeout    <= pwdata[SpanWidth-1:0];
        REG_NEAR_LIMIT:       cfg.near_limit       <= pwdata[DistWidth-1:0];
        REG_MID_LIMIT:        cfg.mid_limit        <= pwdata[DistWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STALL_TIMEOUT:    prdata = {1'b0, cfg.stall_timeout};
      REG_PRESENT_DEBOUNCE: prdata = {1'b0, cfg.present_debounce};
      REG_CLEAR_TIMEOUT:    prdata = {1'b0, cfg.clear_timeout};
      REG_NEAR_LIMIT:       prdata = {16'd0, cfg.near_limit};
      REG_MID_LIMIT:        prdata = {16'd0, cfg.mid_limit};
      default:              prdata = '0;
    endcase
  end

  // input register moves on when the result register is free or being drained
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.command           <= command;
      item.now_ms            <= now_ms;
      item.frame_is_presence <= frame_is_presence;
      item.target_hit        <= target_hit;
      item.raw_targets       <= raw_targets;
      item.range_cm          <= range_cm;
    end
  end

  rpd_step u_step (
    .cfg (cfg),
    .item(item),
    .cur (state),
    .nxt (state_next),
    .res (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.presence        <= PRES_UNKNOWN;
      state.count           <= 2'd0;
      state.range           <= 2'd0;
      state.last_frame      <= '0;
      state.target_start    <= '0;
      state.absence_start   <= '0;
      state.last_raw_target <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

  assign presence_state = result.presence;
  assign count_bucket   = result.count;
  assign range_band     = result.range;
  assign presence_chg   = result.presence_chg;
  assign bucket_chg     = result.bucket_chg;
  assign stalled        = result.stalled;

endmodule

>>> rtl/rpd_checker.sv
// Port-level checker for the presence debouncer, bound to the top level.
`timescale 1ns / 1ps
module rpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] presence_state,
  input logic [1:0] count_bucket,
  input logic [1:0] range_band,
  input logic       presence_chg,
  input logic       bucket_chg,
  input logic       stalled
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && stalled |->
      presence_state == 2'd0 && presence_chg && !bucket_chg &&
      count_bucket == 2'd0 && range_band == 2'd0)
    else $error("stall word not forced to unknown");

  a_unknown_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && presence_state == 2'd0 |-> count_bucket == 2'd0 && range_band == 2'd0)
    else $error("unknown state with nonzero count or range");

  a_drain_frees_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |-> !in_stall)
    else $error("input stalled while result drains");

  a_held_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(presence_state) &&
      $stable(count_bucket) && $stable(range_band))
    else $error("held result word changed");

endmodule

bind radar_presence_debounce_fsm rpd_checker u_rpd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .presence_state(presence_state),
  .count_bucket  (count_bucket),
  .range_band    (range_band),
  .presence_chg  (presence_chg),
  .bucket_chg    (bucket_chg),
  .stalled       (stalled)
);

>>> test/tb_radar_presence_debounce_fsm.sv
// Testbench: paced ticks and APB settings for radar_presence_debounce_fsm, checked per word.
`timescale 1ns / 1ps

import rpd_pkg::*;

class debounce_tracker;
  logic [SpanWidth-1:0] stall_to;
  logic [SpanWidth-1:0] debounce_to;
  logic [SpanWidth-1:0] clear_to;
  logic [DistWidth-1:0] near_lim;
  logic [DistWidth-1:0] mid_lim;

  presence_t            pres;
  logic [1:0]           bucket;
  logic [1:0]           band;
  logic [TimeWidth-1:0] last_frame;
  logic [TimeWidth-1:0] target_since;
  logic [TimeWidth-1:0] absence_since;
  bit                   last_target;

  rpd_result_t pending_reports[$];
  int mismatches;
  int ticks;
  int checked;
  int restarts;
  int stalls;
  int changes;

  function new();
    stall_to    = StallTimeoutReset;
    debounce_to = PresentDebounceReset;
    clear_to    = ClearTimeoutReset;
    near_lim    = NearLimitReset;
    mid_lim     = MidLimitReset;
    rearm('0);
  endfunction

  function void rearm(logic [TimeWidth-1:0] t);
    pres          = PRES_UNKNOWN;
    bucket        = 2'd0;
    band          = 2'd0;
    last_frame    = t;
    target_since  = t;
    absence_since = t;
    last_target   = 1'b0;
  endfunction

  function void set_register(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_STALL_TIMEOUT:    stall_to    = v[SpanWidth-1:0];
      REG_PRESENT_DEBOUNCE: debounce_to = v[SpanWidth-1:0];
      REG_CLEAR_TIMEOUT:    clear_to    = v[SpanWidth-1:0];
      REG_NEAR_LIMIT:       near_lim    = v[DistWidth-1:0];
      REG_MID_LIMIT:        mid_lim     = v[DistWidth-1:0];
      default: ;
    endcase
  endfunction

  // wrap-safe: now - since must be non-negative as a signed 32-bit value and reach span
  function bit span_ok(logic [TimeWidth-1:0] now, logic [TimeWidth-1:0] since,
                       logic [SpanWidth-1:0] span);
    logic [TimeWidth-1:0] d;
    d = now - since;
    return !d[TimeWidth-1] && (d >= {1'b0, span});
  endfunction

  function void note_tick(rpd_item_t w);
    rpd_result_t r;
    presence_t   prev_pres;
    logic [1:0]  prev_bucket;
    prev_pres     = pres;
    prev_bucket   = bucket;
    r.presence_chg = 1'b0;
    r.bucket_chg   = 1'b0;
    r.stalled      = 1'b0;
    if (w.command) begin
      rearm(w.now_ms);
      r.presence_chg = (prev_pres != PRES_UNKNOWN);
      restarts++;
    end else if (pres != PRES_UNKNOWN && span_ok(w.now_ms, last_frame, stall_to)) begin
      pres   = PRES_UNKNOWN;
      bucket = 2'd0;
      band   = 2'd0;
      r.presence_chg = 1'b1;
      r.stalled      = 1'b1;
      stalls++;
    end else if (w.frame_is_presence) begin
      last_frame = w.now_ms;
      if (w.target_hit && !last_target) target_since = w.now_ms;
      else if (!w.target_hit && last_target) absence_since = w.now_ms;
      last_target = w.target_hit;
      if (w.target_hit) begin
        if (pres != PRES_PRESENT && span_ok(w.now_ms, target_since, debounce_to))
          pres = PRES_PRESENT;
        else if (pres == PRES_UNKNOWN)
          pres = PRES_CLEAR;
        bucket = (w.raw_targets == 8'd0) ? 2'd0 : (w.raw_targets == 8'd1) ? 2'd1 : 2'd2;
        band   = (w.range_cm == '0) ? 2'd0 :
                 (w.range_cm <= near_lim) ? 2'd1 :
                 (w.range_cm <= mid_lim) ? 2'd2 : 2'd3;
      end else begin
        if (pres != PRES_CLEAR && span_ok(w.now_ms, absence_since, clear_to))
          pres = PRES_CLEAR;
        else if (pres == PRES_UNKNOWN)
          pres = PRES_CLEAR;
        bucket = 2'd0;
        band   = 2'd0;
      end
      r.presence_chg = (pres != prev_pres);
      r.bucket_chg   = (bucket != prev_bucket);
    end
    r.presence = pres;
    r.count    = bucket;
    r.range    = band;
    if (r.presence_chg) changes++;
    ticks++;
    pending_reports.push_back(r);
  endfunction

  function void cmp(string nm, logic [1:0] e, logic [1:0] a);
    if (a !== e) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
      mismatches++;
    end
  endfunction

  function void check_report(rpd_result_t a);
    rpd_result_t e;
    if (pending_reports.size() == 0) begin
      $display("%0t ns: result word with no tick outstanding (state %0d)", $time, a.presence);
      mismatches++;
      return;
    end
    e = pending_reports.pop_front();
    checked++;
    cmp("presence_state", e.presence, a.presence);
    cmp("count_bucket", e.count, a.count);
    cmp("range_band", e.range, a.range);
    cmp("presence_chg", {1'b0, e.presence_chg}, {1'b0, a.presence_chg});
    cmp("bucket_chg", {1'b0, e.bucket_chg}, {1'b0, a.bucket_chg});
    cmp("stalled", {1'b0, e.stalled}, {1'b0, a.stalled});
  endfunction
endclass

module tb_radar_presence_debounce_fsm;
  localparam int CycleLimit = 200000;
  localparam logic [2:0] UnusedReg = 3'd6;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  rpd_item_t word;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] presence_state;
  logic [1:0] count_bucket;
  logic [1:0] range_band;
  logic presence_chg;
  logic bucket_chg;
  logic stalled;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  debounce_tracker sb;
  int send_idle_pct;
  int recv_idle_pct;
  int cycles;
  logic [TimeWidth-1:0] cursor_ms;
  bit target_run;

  radar_presence_debounce_fsm i_dut (
    .clk, .rst, .in_valid, .in_stall,
    .command(word.command), .now_ms(word.now_ms),
    .frame_is_presence(word.frame_is_presence), .target_hit(word.target_hit),
    .raw_targets(word.raw_targets), .range_cm(word.range_cm),
    .out_valid, .out_stall, .presence_state, .count_bucket, .range_band,
    .presence_chg, .bucket_chg, .stalled,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycles,
               sb.pending_reports.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= (!rst && $urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    rpd_result_t a;
    if (!rst && in_valid && !in_stall) sb.note_tick(word);
    if (!rst && out_valid && !out_stall) begin
      a.presence     = presence_t'(presence_state);
      a.count        = count_bucket;
      a.range        = range_band;
      a.presence_chg = presence_chg;
      a.bucket_chg   = bucket_chg;
      a.stalled      = stalled;
      sb.check_report(a);
    end
  end

  function automatic rpd_item_t mk_tick(bit cmd, logic [31:0] now, bit frame, bit tgt,
                                        logic [7:0] cnt, logic [15:0] cm);
    rpd_item_t w;
    w.command           = cmd;
    w.now_ms            = now;
    w.frame_is_presence = frame;
    w.target_hit        = tgt;
    w.raw_targets       = cnt;
    w.range_cm          = cm;
    return w;
  endfunction

  task automatic send_tick(input rpd_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    word     <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // junk above each field width checks that the registers truncate
  task automatic cfg_all(input logic [30:0] stall_v, input logic [30:0] deb_v,
                         input logic [30:0] clr_v, input logic [15:0] near_v,
                         input logic [15:0] mid_v);
    cfg_write(REG_STALL_TIMEOUT, {1'($urandom_range(1)), stall_v});
    cfg_write(REG_PRESENT_DEBOUNCE, {1'($urandom_range(1)), deb_v});
    cfg_write(REG_CLEAR_TIMEOUT, {1'($urandom_range(1)), clr_v});
    cfg_write(REG_NEAR_LIMIT, {16'($urandom()), near_v});
    cfg_write(REG_MID_LIMIT, {16'($urandom()), mid_v});
  endtask

  task automatic wait_drained();
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic make_random_tick(output rpd_item_t w);
    int r;
    logic [7:0] cnt;
    logic [15:0] cm_v;
    r = $urandom_range(99);
    case ($urandom_range(5))
      0: cnt = 8'd0;
      1: cnt = 8'd1;
      2: cnt = 8'd2;
      default: cnt = 8'($urandom_range(255));
    endcase
    case ($urandom_range(7))
      0: cm_v = '0;
      1: cm_v = sb.near_lim;
      2: cm_v = sb.near_lim + 16'd1;
      3: cm_v = sb.mid_lim;
      4: cm_v = sb.mid_lim + 16'd1;
      5: cm_v = 16'hFFFF;
      default: cm_v = 16'($urandom_range(65535));
    endcase
    if ($urandom_range(9) == 0) cursor_ms += $urandom_range(0, 8000);
    else cursor_ms += $urandom_range(0, 400);
    if ($urandom_range(11) == 0) target_run = !target_run;
    if (r < 3)
      w = mk_tick(1'b1, cursor_ms, 1'($urandom_range(1)), 1'($urandom_range(1)), cnt, cm_v);
    else if (r < 10)
      w = mk_tick(1'b0, cursor_ms, 1'b0, 1'($urandom_range(1)), cnt, cm_v);
    else if (r < 14)
      w = mk_tick(1'b0, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)), cnt, cm_v);
    else
      w = mk_tick(1'b0, cursor_ms, 1'b1, target_run, cnt, cm_v);
  endtask

  task automatic run_random(input int n);
    rpd_item_t w;
    cursor_ms  = $urandom();
    target_run = 1'b0;
    repeat (n) begin
      make_random_tick(w);
      send_tick(w);
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    sb        = new();
    cycles    = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    word      = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    send_idle_pct = 37;
    recv_idle_pct = 61;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    cfg_all(31'd3000, 31'd1000, 31'd5000, 16'd100, 16'd300);
    send_tick(mk_tick(1'b0, 32'd0, 1'b0, 1'b0, 8'd0, 16'd0));
    send_tick(mk_tick(1'b0, 32'd100, 1'b1, 1'b0, 8'd255, 16'hFFFF));
    send_tick(mk_tick(1'b0, 32'd200, 1'b1, 1'b1, 8'd1, 16'd50));
    send_tick(mk_tick(1'b0, 32'd1200, 1'b1, 1'b1, 8'd2, 16'd100));
    send_tick(mk_tick(1'b0, 32'd1300, 1'b1, 1'b1, 8'd255, 16'd101));
    send_tick(mk_tick(1'b0, 32'd1400, 1'b1, 1'b1, 8'd0, 16'd300));
    send_tick(mk_tick(1'b0, 32'd1500, 1'b1, 1'b1, 8'd1, 16'd301));
    send_tick(mk_tick(1'b0, 32'd1600, 1'b1, 1'b1, 8'd1, 16'd0));
    send_tick(mk_tick(1'b0, 32'd1700, 1'b1, 1'b0, 8'd7, 16'd40));
    send_tick(mk_tick(1'b0, 32'd4000, 1'b1, 1'b0, 8'd0, 16'd0));
    send_tick(mk_tick(1'b0, 32'd6700, 1'b1, 1'b0, 8'd0, 16'd0));
    send_tick(mk_tick(1'b0, 32'd9800, 1'b0, 1'b0, 8'd0, 16'd0));
    send_tick(mk_tick(1'b0, 32'd9900, 1'b1, 1'b1, 8'd3, 16'hFFFF));
    send_tick(mk_tick(1'b1, 32'hFFFF_FF00, 1'b1, 1'b1, 8'd9, 16'd10));
    send_tick(mk_tick(1'b1, 32'hFFFF_FF00, 1'b0, 1'b0, 8'd0, 16'd0));
    send_tick(mk_tick(1'b0, 32'hFFFF_FFF0, 1'b1, 1'b1, 8'd1, 16'd200));
    send_tick(mk_tick(1'b0, 32'h0000_03E0, 1'b1, 1'b1, 8'd2, 16'd250));
    send_tick(mk_tick(1'b0, 32'h0000_0100, 1'b1, 1'b1, 8'd128, 16'd1));
    send_tick(mk_tick(1'b0, 32'h8000_0100, 1'b0, 1'b1, 8'd5, 16'd5));
    send_tick(mk_tick(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'hFF, 16'hFFFF));
    send_tick(mk_tick(1'b1, 32'h0000_0000, 1'b1, 1'b1, 8'hFF, 16'hFFFF));
    run_random(140);

    send_idle_pct = 61;
    recv_idle_pct = 37;
    cfg_all(31'h7FFF_FFFF, 31'd0, 31'd0, 16'hFFFF, 16'd0);
    cfg_write(UnusedReg, $urandom());
    run_random(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_all(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd0, 16'hFFFF);
    run_random(40);
    cfg_all(31'($urandom_range(2000, 6000)), 31'($urandom_range(100, 1500)),
            31'($urandom_range(300, 4000)), 16'($urandom_range(20, 200)),
            16'($urandom_range(150, 600)));
    run_random(110);

    $display("Ran %0d ticks over four register settings and three pacing modes, %0d checked",
             sb.ticks, sb.checked);
    $display("Seen: %0d restarts, %0d stall fallbacks, %0d presence changes, %0d mismatches",
             sb.restarts, sb.stalls, sb.changes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
